// ===== sv/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg: shared constants for the quaternion to Euler angle pipeline
// Angle constants in Q16.16, the CORDIC arctangent table and a bit search.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

    localparam int ZW         = 20;   // CORDIC angle accumulator width
    localparam int NORM_EXP   = 40;   // operands are scaled until one reaches 2^40
    localparam int ATAN_STEPS = 17;

    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [ZW-1:0] PI_Q16      = 20'sd205887;
    localparam logic signed [22:0]   RAD2DEG_Q16 = 23'sd3754936;

    localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_STEPS] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
        20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
        20'sd8, 20'sd4, 20'sd2, 20'sd1
    };

    // Index of the highest set bit; zero for a zero word.
    function automatic logic [6:0] msb_index(input logic [63:0] v);
        logic [6:0] m;
        m = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                m = 7'(i);
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== sv/qte_isqrt.sv =====
// ----------------------------------------------------------------------------
// qte_isqrt: pipelined integer square root
// Floor square root of a 64-bit word, one result bit per stage, 32 stages.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_v,
    output logic [31:0] o_r
);
    import qte_pkg::*;

    localparam int NS = 32;

    logic [63:0] r_v [NS];
    logic [63:0] r_r [NS];
    logic [63:0] n_v [NS];
    logic [63:0] n_r [NS];

    always_comb begin
        logic [63:0] pv;
        logic [63:0] pr;
        logic [63:0] bt;
        for (int k = 0; k < NS; k++) begin
            pv = (k == 0) ? i_v : r_v[(k == 0) ? 0 : k - 1];
            pr = (k == 0) ? 64'd0 : r_r[(k == 0) ? 0 : k - 1];
            bt = 64'd1 << (62 - 2 * k);
            if (pv >= pr + bt) begin
                n_v[k] = pv - (pr + bt);
                n_r[k] = (pr >> 1) + bt;
            end else begin
                n_v[k] = pv;
                n_r[k] = pr >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_v[k] <= n_v[k];
                r_r[k] <= n_r[k];
            end
        end
    end

    assign o_r = r_r[NS-1][31:0];

endmodule

`default_nettype wire

// ===== sv/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// qte_cordic: pipelined CORDIC two-argument arctangent
// Quadrant fold, operand scaling, then 17 vectoring steps, one per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic #(
    parameter int IW = 50
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [IW-1:0]          i_y,
    input  logic signed [IW-1:0]          i_x,
    output logic signed [qte_pkg::ZW-1:0] o_z
);
    import qte_pkg::*;

    localparam int CW = ((IW > NORM_EXP + 1) ? IW : NORM_EXP + 1) + 3;
    localparam int NS = ATAN_STEPS;
    localparam int NZ = NS + 3;

    logic signed [CW-1:0] xe, ye;
    logic signed [CW-1:0] n_xa, n_ya;
    logic signed [ZW-1:0] n_za;
    logic signed [CW-1:0] r_xa, r_ya, r_xb, r_yb, r_xc, r_yc;
    logic signed [ZW-1:0] r_za, r_zb, r_zc;
    logic [5:0]           r_sh;
    logic                 r_zr [NZ];
    logic signed [CW-1:0] ax, ay;
    logic [CW-1:0]        mg;
    logic [6:0]           msb;
    logic [5:0]           n_sh;
    logic signed [CW-1:0] r_x [NS];
    logic signed [CW-1:0] r_y [NS];
    logic signed [ZW-1:0] r_z [NS];
    logic signed [CW-1:0] n_x [NS];
    logic signed [CW-1:0] n_y [NS];
    logic signed [ZW-1:0] n_z [NS];

    assign xe = CW'(i_x);
    assign ye = CW'(i_y);

    // Fold the left half plane into the right one.
    always_comb begin
        n_xa = xe;
        n_ya = ye;
        n_za = '0;
        if (xe < 0) begin
            if (ye >= 0) begin
                n_xa = ye;
                n_ya = -xe;
                n_za = HALF_PI_Q16;
            end else begin
                n_xa = -ye;
                n_ya = xe;
                n_za = -HALF_PI_Q16;
            end
        end
    end

    assign ax   = (r_xa < 0) ? -r_xa : r_xa;
    assign ay   = (r_ya < 0) ? -r_ya : r_ya;
    assign mg   = $unsigned(ax) | $unsigned(ay);
    assign msb  = msb_index(64'(mg));
    assign n_sh = (msb >= 7'(NORM_EXP)) ? 6'd0 : 6'(NORM_EXP - int'(msb));

    always_comb begin
        logic signed [CW-1:0] px, py;
        logic signed [ZW-1:0] pz;
        for (int k = 0; k < NS; k++) begin
            px = (k == 0) ? r_xc : r_x[(k == 0) ? 0 : k - 1];
            py = (k == 0) ? r_yc : r_y[(k == 0) ? 0 : k - 1];
            pz = (k == 0) ? r_zc : r_z[(k == 0) ? 0 : k - 1];
            if (py > 0) begin
                n_x[k] = px + (py >>> k);
                n_y[k] = py - (px >>> k);
                n_z[k] = pz + ATAN_TAB[k];
            end else begin
                n_x[k] = px - (py >>> k);
                n_y[k] = py + (px >>> k);
                n_z[k] = pz - ATAN_TAB[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xa     <= n_xa;
            r_ya     <= n_ya;
            r_za     <= n_za;
            r_xb     <= r_xa;
            r_yb     <= r_ya;
            r_zb     <= r_za;
            r_sh     <= n_sh;
            r_xc     <= r_xb <<< r_sh;
            r_yc     <= r_yb <<< r_sh;
            r_zc     <= r_zb;
            r_zr[0]  <= (xe == 0) && (ye == 0);
            for (int j = 1; j < NZ; j++) begin
                r_zr[j] <= r_zr[j-1];
            end
            for (int k = 0; k < NS; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
                r_z[k] <= n_z[k];
            end
        end
    end

    assign o_z = r_zr[NZ-1] ? '0 : r_z[NS-1];

endmodule

`default_nettype wire

// ===== sv/quaternion_to_euler_angles.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: Z-Y-X Euler angles from a fixed-point quaternion
// Gives yaw, pitch and roll in Q16.16 radians or degrees, plus a zero-norm flag.
// ----------------------------------------------------------------------------
//  channel  | signals                                       | direction
//  input    | i_in_valid, o_in_ready, i_quat_*              | in
//  output   | o_out_valid, i_out_ready, o_*_angle, o_norm_* | out
//  config   | i_cfg_we, i_cfg_wdata                         | in
//
// One transaction can enter every cycle while the output is not stalled. The
// pipeline holds the 32-stage square root ahead of the pitch CORDIC and the 17
// CORDIC steps. A stall at the output freezes the whole pipeline in place. Reset
// clears the stage valid bits and selects radians.
`default_nettype none

module quaternion_to_euler_angles #(
    parameter int QUAT_WIDTH  = 16,
    parameter int ANGLE_WIDTH = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_real,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_i,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_j,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_k,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [ANGLE_WIDTH-1:0] o_yaw_angle,
    output logic signed [ANGLE_WIDTH-1:0] o_pitch_angle,
    output logic signed [ANGLE_WIDTH-1:0] o_roll_angle,
    output logic                          o_norm_invalid
);
    import qte_pkg::*;

    localparam int EW   = (QUAT_WIDTH > 24) ? 24 : QUAT_WIDTH;
    localparam int DROP = QUAT_WIDTH - EW;
    localparam int PW   = 2 * EW;
    localparam int SW   = 2 * EW + 2;
    localparam int NL   = 60;
    localparam int DS   = 35;
    localparam int DP   = 33;
    localparam int DZ   = 56;
    localparam int MW   = ZW + 23;
    localparam logic signed [MW-1:0] ANG_HI = MW'((64'sd1 <<< (ANGLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [MW-1:0] ANG_LO = -ANG_HI - MW'(1);

    logic                 en;
    logic                 r_deg;
    logic                 r_vld [NL];

    logic signed [EW-1:0] r1_w, r1_x, r1_y, r1_z;
    logic signed [PW-1:0] r2_sw, r2_sx, r2_sy, r2_sz;
    logic signed [PW-1:0] r2_xy, r2_zw, r2_yz, r2_xw, r2_yw, r2_xz;
    logic signed [SW-1:0] r3_yy, r3_yx, r3_ry, r3_rx, r3_n, r3_a;
    logic                 r3_zero;
    logic signed [SW-1:0] ac, aa;
    logic [6:0]           nmsb;
    logic [SW-1:0]        r4_n, r4_aa;
    logic [4:0]           r4_s;
    logic                 r4_neg;
    logic [63:0]          nn64, aa64;
    logic [31:0]          r5_d, r5_sm;
    logic [30:0]          r5_aa;
    logic                 r5_neg;
    logic [63:0]          n_p, r6_p;
    logic [31:0]          sq;

    logic signed [SW-1:0] r_dyy [DS];
    logic signed [SW-1:0] r_dyx [DS];
    logic signed [SW-1:0] r_dry [DS];
    logic signed [SW-1:0] r_drx [DS];
    logic [30:0]          r_daa [DP];
    logic                 r_dng [DP];
    logic                 r_dz  [DZ];

    logic signed [32:0]   py, px;
    logic signed [ZW-1:0] z_yaw, z_pitch, z_roll;
    logic signed [ZW-1:0] r_fy, r_fp, r_fr;
    logic signed [MW-1:0] r_my, r_mp, r_mr;
    logic signed [ANGLE_WIDTH-1:0] r_oy, r_op, r_or;
    logic                 r_inv;

    function automatic logic signed [ZW-1:0] clamp_z(input logic signed [ZW-1:0] v,
                                                     input logic signed [ZW-1:0] lim);
        logic signed [ZW-1:0] c;
        c = v;
        if (v > lim) begin
            c = lim;
        end else if (v < -lim) begin
            c = -lim;
        end
        return c;
    endfunction

    function automatic logic signed [ANGLE_WIDTH-1:0] finish(input logic signed [ZW-1:0] v,
                                                             input logic signed [MW-1:0] m,
                                                             input logic deg);
        logic signed [MW-1:0] t;
        t = deg ? ((m + MW'(32768)) >>> 16) : MW'(v);
        if (t > ANG_HI) begin
            t = ANG_HI;
        end else if (t < ANG_LO) begin
            t = ANG_LO;
        end
        return t[ANGLE_WIDTH-1:0];
    endfunction

    assign en         = !r_vld[NL-1] || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg <= 1'b0;
        end else if (i_cfg_we) begin
            r_deg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NL; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int j = 1; j < NL; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    // Pitch argument: clamp to the norm, then scale both below 2^31.
    assign ac   = (r3_a > r3_n) ? r3_n : ((r3_a < -r3_n) ? -r3_n : r3_a);
    assign aa   = (ac < 0) ? -ac : ac;
    assign nmsb = msb_index(64'($unsigned(r3_n)));
    assign nn64 = 64'(r4_n) >> r4_s;
    assign aa64 = 64'(r4_aa) >> r4_s;
    assign n_p  = r5_d * r5_sm;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_w    <= EW'(i_quat_real >>> DROP);
            r1_x    <= EW'(i_quat_i >>> DROP);
            r1_y    <= EW'(i_quat_j >>> DROP);
            r1_z    <= EW'(i_quat_k >>> DROP);

            r2_sw   <= r1_w * r1_w;
            r2_sx   <= r1_x * r1_x;
            r2_sy   <= r1_y * r1_y;
            r2_sz   <= r1_z * r1_z;
            r2_xy   <= r1_x * r1_y;
            r2_zw   <= r1_z * r1_w;
            r2_yz   <= r1_y * r1_z;
            r2_xw   <= r1_x * r1_w;
            r2_yw   <= r1_y * r1_w;
            r2_xz   <= r1_x * r1_z;

            r3_yy   <= (SW'(r2_xy) + SW'(r2_zw)) <<< 1;
            r3_yx   <= SW'(r2_sx) - SW'(r2_sy) - SW'(r2_sz) + SW'(r2_sw);
            r3_ry   <= (SW'(r2_yz) + SW'(r2_xw)) <<< 1;
            r3_rx   <= SW'(r2_sz) + SW'(r2_sw) - SW'(r2_sx) - SW'(r2_sy);
            r3_n    <= SW'(r2_sw) + SW'(r2_sx) + SW'(r2_sy) + SW'(r2_sz);
            r3_a    <= (SW'(r2_yw) - SW'(r2_xz)) <<< 1;
            r3_zero <= (r2_sw == 0) && (r2_sx == 0) && (r2_sy == 0) && (r2_sz == 0);

            r4_n    <= $unsigned(r3_n);
            r4_aa   <= $unsigned(aa);
            r4_neg  <= r3_a < 0;
            r4_s    <= (nmsb >= 7'd31) ? 5'(nmsb - 7'd30) : 5'd0;

            r5_d    <= {1'b0, nn64[30:0]} - {1'b0, aa64[30:0]};
            r5_sm   <= {1'b0, nn64[30:0]} + {1'b0, aa64[30:0]};
            r5_aa   <= aa64[30:0];
            r5_neg  <= r4_neg;

            r6_p    <= n_p;

            r_dyy[0] <= r3_yy;
            r_dyx[0] <= r3_yx;
            r_dry[0] <= r3_ry;
            r_drx[0] <= r3_rx;
            for (int j = 1; j < DS; j++) begin
                r_dyy[j] <= r_dyy[j-1];
                r_dyx[j] <= r_dyx[j-1];
                r_dry[j] <= r_dry[j-1];
                r_drx[j] <= r_drx[j-1];
            end
            r_daa[0] <= r5_aa;
            r_dng[0] <= r5_neg;
            for (int j = 1; j < DP; j++) begin
                r_daa[j] <= r_daa[j-1];
                r_dng[j] <= r_dng[j-1];
            end
            r_dz[0] <= r3_zero;
            for (int j = 1; j < DZ; j++) begin
                r_dz[j] <= r_dz[j-1];
            end
        end
    end

    qte_isqrt u_isqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_v   (r6_p),
        .o_r   (sq)
    );

    assign py = r_dng[DP-1] ? -$signed({2'b00, r_daa[DP-1]}) : $signed({2'b00, r_daa[DP-1]});
    assign px = $signed({1'b0, sq});

    qte_cordic #(.IW(SW)) u_yaw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (r_dyy[DS-1]),
        .i_x   (r_dyx[DS-1]),
        .o_z   (z_yaw)
    );

    qte_cordic #(.IW(33)) u_pitch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (py),
        .i_x   (px),
        .o_z   (z_pitch)
    );

    qte_cordic #(.IW(SW)) u_roll (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (r_dry[DS-1]),
        .i_x   (r_drx[DS-1]),
        .o_z   (z_roll)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fy  <= clamp_z(z_yaw, PI_Q16);
            r_fp  <= clamp_z(z_pitch, HALF_PI_Q16);
            r_fr  <= clamp_z(z_roll, PI_Q16);
            r_my  <= MW'(clamp_z(z_yaw, PI_Q16)) * MW'(RAD2DEG_Q16);
            r_mp  <= MW'(clamp_z(z_pitch, HALF_PI_Q16)) * MW'(RAD2DEG_Q16);
            r_mr  <= MW'(clamp_z(z_roll, PI_Q16)) * MW'(RAD2DEG_Q16);

            r_inv <= r_dz[DZ-1];
            r_oy  <= r_dz[DZ-1] ? '0 : finish(r_fy, r_my, r_deg);
            r_op  <= r_dz[DZ-1] ? '0 : finish(r_fp, r_mp, r_deg);
            r_or  <= r_dz[DZ-1] ? '0 : finish(r_fr, r_mr, r_deg);
        end
    end

    assign o_out_valid    = r_vld[NL-1];
    assign o_yaw_angle    = r_oy;
    assign o_pitch_angle  = r_op;
    assign o_roll_angle   = r_or;
    assign o_norm_invalid = r_inv;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_norm_invalid |->
            o_yaw_angle == 0 && o_pitch_angle == 0 && o_roll_angle == 0)
        else $error("invalid norm with nonzero angle");

    // The pitch clamp sits just above pi/2, so in degrees it lands slightly past 90.
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $signed(o_pitch_angle) <= 5898256 &&
                        $signed(o_pitch_angle) >= -5898256)
        else $error("pitch out of range");

    a_yaw_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $signed(o_yaw_angle) <= 11796480 &&
                        $signed(o_yaw_angle) >= -11796480 &&
                        $signed(o_roll_angle) <= 11796480 &&
                        $signed(o_roll_angle) >= -11796480)
        else $error("yaw or roll out of range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> o_out_valid)
        else $error("pipeline lost a stalled transaction");
`endif

endmodule

`default_nettype wire

// ===== verif/quaternion_to_euler_angles_tb.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_tb: self-checking bench for the Euler angle block
// Drives quaternions through the valid/ready input, predicts yaw, pitch and
// roll with a bit-exact CORDIC model and compares every output transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QW = 16;
    localparam int AW = 25;
    localparam int LATENCY = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam longint NORM_LEVEL = 64'sd1 << 40;
    localparam longint HALF_PI = 102944;
    localparam longint FULL_PI = 205887;
    localparam longint TO_DEG = 3754936;

    typedef struct {
        logic signed [AW-1:0] yaw;
        logic signed [AW-1:0] pitch;
        logic signed [AW-1:0] roll;
        logic                 invalid;
    } euler_t;

    // Vectoring-mode CORDIC arctangent with a quadrant pre-rotation.
    function automatic longint cordic_atan2(longint y, longint x);
        longint arc_tab [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                 256, 128, 64, 32, 16, 8, 4, 2, 1};
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = HALF_PI;
            end else begin
                x = -y; y = t; z = -HALF_PI;
            end
        end
        while ((x < 0 ? -x : x) < NORM_LEVEL && (y < 0 ? -y : y) < NORM_LEVEL) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < 17; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y > 0) begin
                x += dy; y -= dx; z += arc_tab[i];
            end else begin
                x -= dy; y += dx; z -= arc_tab[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [AW-1:0] scale_angle(longint rad, longint lim, bit deg);
        longint v;
        longint hi;
        hi = (64'sd1 << (AW - 1)) - 1;
        v = rad > lim ? lim : (rad < -lim ? -lim : rad);
        if (deg) v = (v * TO_DEG + 32768) >>> 16;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v[AW-1:0];
    endfunction

    function automatic euler_t quat_to_euler(logic signed [QW-1:0] qw,
                                             logic signed [QW-1:0] qx,
                                             logic signed [QW-1:0] qy,
                                             logic signed [QW-1:0] qz, bit deg);
        euler_t e;
        longint w, x, y, z, sw, sx, sy, sz, n, a, aa, nn;
        longint unsigned c;
        w = qw; x = qx; y = qy; z = qz;
        sw = w * w; sx = x * x; sy = y * y; sz = z * z;
        n = sw + sx + sy + sz;
        e = '{yaw: '0, pitch: '0, roll: '0, invalid: 1'b1};
        if (n == 0) return e;
        e.invalid = 1'b0;
        e.yaw = scale_angle(cordic_atan2(2 * (x * y + z * w), sx - sy - sz + sw), FULL_PI, deg);
        e.roll = scale_angle(cordic_atan2(2 * (y * z + x * w), -sx - sy + sz + sw), FULL_PI, deg);
        a = 2 * (y * w - x * z);
        a = a > n ? n : (a < -n ? -n : a);
        aa = a < 0 ? -a : a;
        nn = n;
        while (nn >= (64'sd1 << 31)) begin
            nn >>= 1;
            aa >>= 1;
        end
        c = int_sqrt(longint'(unsigned'(nn - aa) * unsigned'(nn + aa)));
        e.pitch = scale_angle(cordic_atan2(a < 0 ? -aa : aa, longint'(c)), HALF_PI, deg);
        return e;
    endfunction

    class angle_scoreboard;
        euler_t pending_angles[$];
        int     mismatches;

        function void note_quat(logic signed [QW-1:0] w, logic signed [QW-1:0] x,
                                logic signed [QW-1:0] y, logic signed [QW-1:0] z, bit deg);
            pending_angles.push_back(quat_to_euler(w, x, y, z, deg));
        endfunction

        function void check_angles(euler_t got);
            euler_t want;
            if (pending_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: output transaction with none expected");
                return;
            end
            want = pending_angles.pop_front();
            if (got.yaw !== want.yaw || got.pitch !== want.pitch ||
                got.roll !== want.roll || got.invalid !== want.invalid) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: exp yaw %0d pitch %0d roll %0d inv %0b, got %0d %0d %0d %0b",
                             want.yaw, want.pitch, want.roll, want.invalid,
                             got.yaw, got.pitch, got.roll, got.invalid);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [QW-1:0] i_quat_real = '0, i_quat_i = '0, i_quat_j = '0, i_quat_k = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [AW-1:0] o_yaw_angle, o_pitch_angle, o_roll_angle;
    logic o_norm_invalid;

    angle_scoreboard sb = new();
    bit  in_degrees = 1'b0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_requests = 0;
    int  quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    quaternion_to_euler_angles #(.QUAT_WIDTH(QW), .ANGLE_WIDTH(AW)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_quat_real(i_quat_real), .i_quat_i(i_quat_i),
        .i_quat_j(i_quat_j), .i_quat_k(i_quat_k),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_yaw_angle(o_yaw_angle), .o_pitch_angle(o_pitch_angle),
        .o_roll_angle(o_roll_angle), .o_norm_invalid(o_norm_invalid)
    );

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(posedge i_clk) begin : receiver
        int hold_left;
        int seen_requests;
        if (hold_requests != seen_requests) begin
            seen_requests = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_angles('{yaw: o_yaw_angle, pitch: o_pitch_angle,
                              roll: o_roll_angle, invalid: o_norm_invalid});
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("quaternion_to_euler_angles_tb: done, errors");
            $finish;
        end
    end

    task automatic send_quat(logic signed [QW-1:0] w, logic signed [QW-1:0] x,
                             logic signed [QW-1:0] y, logic signed [QW-1:0] z);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_quat_real <= w;
        i_quat_i <= x;
        i_quat_j <= y;
        i_quat_k <= z;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_quat(w, x, y, z, in_degrees);
    endtask

    // Only touched once the pipeline has emptied out.
    task automatic set_units(bit deg);
        i_in_valid <= 1'b0;
        while (sb.pending_angles.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= deg;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        in_degrees = deg;
    endtask

    task automatic send_random_quat();
        logic signed [QW-1:0] q [4];
        int r;
        for (int k = 0; k < 4; k++) q[k] = QW'($urandom);
        case ($urandom_range(0, 9))
            4: for (int k = 0; k < 4; k++) q[k] = QW'($urandom_range(0, 8) - 4);
            5: begin
                // Gimbal lock: the arcsine argument lands exactly on plus or minus one.
                r = $urandom_range(1, 32767);
                if ($urandom_range(0, 1)) r = -r;
                q[0] = QW'(r);
                q[2] = $urandom_range(0, 1) ? QW'(r) : QW'(-r);
                q[1] = '0;
                q[3] = '0;
                if ($urandom_range(0, 1)) begin
                    q[1] = q[0]; q[3] = QW'(-q[2]); q[0] = '0; q[2] = '0;
                end
            end
            6: for (int k = 0; k < 4; k++) if ($urandom_range(0, 1)) q[k] = '0;
            7: if ($urandom_range(0, 3) == 0) q = '{default: '0};
            8: begin
                q[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                for (int k = 0; k < 4; k++) if ($urandom_range(0, 2) == 0) q[k] = '0;
            end
            default: ;
        endcase
        send_quat(q[0], q[1], q[2], q[3]);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int u = 0; u < 2; u++) begin
            set_units(u[0]);
            send_quat(0, 0, 0, 0);
            send_quat(16384, 0, 0, 0);
            send_quat(0, 16384, 0, 0);
            send_quat(0, 0, 16384, 0);
            send_quat(0, 0, 0, 16384);
            send_quat(-16384, 0, 0, 0);
            send_quat(0, 0, 0, -16384);
            send_quat(-32768, -32768, -32768, -32768);
            send_quat(32767, 32767, 32767, 32767);
            send_quat(32767, -32768, 32767, -32768);
            send_quat(11585, 0, 11585, 0);
            send_quat(11585, 0, -11585, 0);
            send_quat(0, -32768, 0, 32767);
            send_quat(1, 0, 0, 0);
            send_quat(0, -1, 1, 0);
            send_quat(-1, -1, -1, -1);
        end

        for (int p = 0; p < 6; p++) begin
            set_units(p[0] ^ 1'b1);
            send_idle_pct = (p < 2) ? 15 : (p < 4) ? 85 : 0;
            recv_idle_pct = (p < 2) ? 85 : (p < 4) ? 15 : 0;
            if (p == 4) hold_requests++;
            repeat (165) send_random_quat();
        end
        set_units(1'b0);

        if (sb.mismatches == 0) begin
            $display("quaternion_to_euler_angles_tb: done, clean");
        end else begin
            $display("quaternion_to_euler_angles_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
